>>> hdl/lxz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lxz_pkg
// Shared types, widths, constants and helpers for the Lab to XYZ converter.
// ----------------------------------------------------------------------------
package lxz_pkg;

    // Field widths
    localparam int L_W         = 15;
    localparam int AB_W        = 16;
    localparam int W_W         = 16;
    localparam int OUT_W       = 18;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_Z = 2'd2;

    localparam logic [W_W-1:0] WHITE_X_RST = 16'd24332;
    localparam logic [W_W-1:0] WHITE_Y_RST = 16'd25600;
    localparam logic [W_W-1:0] WHITE_Z_RST = 16'd27874;

    // Q24 term formats
    localparam int FRAC    = 24;
    localparam int TERM_W  = 27;
    localparam int FY_W    = 25;
    localparam int CUBE_W  = 19;
    localparam int LOW_W   = 11;
    localparam int BIAS_W  = 22;
    localparam int ABS_D_W = 25;

    // Pipeline latencies
    localparam int DIV_LAT    = 3;
    localparam int CUBE_LAT   = 4;
    localparam int EXP_LAT    = DIV_LAT + 4;
    localparam int PIPE_LAT   = EXP_LAT + DIV_LAT + 2;
    localparam int CUBE_DLY   = DIV_LAT + 3 - CUBE_LAT;
    localparam int FLAG_DLY   = DIV_LAT + 2;
    localparam int Y_CUBE_DLY = EXP_LAT - 1 - CUBE_LAT;
    localparam int Y_SIDE_DLY = EXP_LAT - 1;

    // Low segment fy: 564*L + floor((L*216908 + 112912) / 225825) + 16/116
    localparam int FYL_X_W   = 29;
    localparam int FYL_Q_W   = 11;
    localparam int FYL_DIV   = 225825;
    localparam int FYL_MULT  = 216908;
    localparam int FYL_HALF  = 112912;
    localparam int FYL_WHOLE = 564;

    // High segment fy: floor(((L + 4096)*16384 + 14) / 29)
    localparam int FYH_X_W  = 30;
    localparam int FYH_Q_W  = 25;
    localparam int FYH_DIV  = 29;
    localparam int FYH_HALF = 14;
    localparam int L_BIAS   = 4096;

    // Low segment Y: floor(((5*L*Y0 + 578112) >> 7) / 9033)
    localparam int YL_X_W  = 23;
    localparam int YL_Q_W  = 10;
    localparam int YL_DIV  = 9033;
    localparam int YL_HALF = 578112;
    localparam int YL_SH   = 7;

    // a/500 and b/200 magnitudes
    localparam int A_X_W  = 30;
    localparam int A_Q_W  = 23;
    localparam int A_DIV  = 125;
    localparam int A_HALF = 62;
    localparam int B_X_W  = 29;
    localparam int B_Q_W  = 24;
    localparam int B_DIV  = 25;
    localparam int B_HALF = 12;

    // Linear segment: floor(((|d|*W*1000 + 7787*2^23) >> 24) / 7787)
    localparam int LIN_X_W   = 27;
    localparam int LIN_Q_W   = 15;
    localparam int LIN_DIV   = 7787;
    localparam int LIN_SCALE = 1000;
    localparam int LIN_SUM_W = 52;
    localparam logic [LIN_SUM_W-1:0] LIN_HALF = LIN_SUM_W'(64'd7787 << (FRAC - 1));

    localparam logic [BIAS_W-1:0] FY_OFFSET =
        BIAS_W'(((64'd16 << FRAC) + 64'd58) / 64'd116);
    localparam logic signed [TERM_W-1:0] KNEE_Q =
        TERM_W'(((64'd2069 << FRAC) + 64'd5000) / 64'd10000);
    localparam logic signed [TERM_W-1:0] LIN_OFFSET =
        TERM_W'(((64'd13793 << FRAC) + 64'd50000) / 64'd100000);

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;

    typedef struct packed {
        logic              low;
        logic              a_neg;
        logic              b_neg;
        logic              last;
        logic [BIAS_W-1:0] bias;
    } prep_side_t;

    typedef struct packed {
        logic              low;
        logic [YL_Q_W-1:0] ylow;
    } y_side_t;

    typedef struct packed {
        logic lin;
        logic neg;
    } lin_flags_t;

    function automatic logic signed [OUT_W-1:0] sat_cube(input logic [CUBE_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > CUBE_W'(OUT_MAX))
        begin
            r = OUT_MAX;
        end
        else
        begin
            r = signed'(OUT_W'(v));
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/lxz_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lxz_delay
// Enabled shift line that keeps side data aligned with pipeline stages.
// ----------------------------------------------------------------------------
module lxz_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule
`default_nettype wire

>>> hdl/lxz_const_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lxz_const_div
// Three-stage floor division by a constant: reciprocal multiply, back
// multiply, then a single remainder correction.
// ----------------------------------------------------------------------------
module lxz_const_div
    import lxz_pkg::*;
#(
    parameter int XW      = 30,
    parameter int QW      = 25,
    parameter int DIVISOR = 29
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [XW-1:0] dividend,
    output logic      [QW-1:0] quotient
);

    localparam int SH = XW;
    localparam int MW = SH - $clog2(DIVISOR + 1) + 2;
    localparam int PW = XW + MW;
    localparam logic [MW-1:0] MULT = MW'((64'd1 << SH) / 64'(DIVISOR));
    localparam logic [XW-1:0] DIV_X = XW'(DIVISOR);

    logic [PW-1:0] prod_reg, prod_next;
    logic [XW-1:0] x1_reg;
    logic [XW-1:0] x2_reg;
    logic [QW-1:0] q0_reg, q0_next;
    logic [XW-1:0] qd_reg, qd_next;
    logic [XW-1:0] rem;
    logic [QW-1:0] q_reg, q_next;

    always_comb
    begin
        prod_next = PW'(dividend) * PW'(MULT);
        q0_next   = QW'(prod_reg >> SH);
        qd_next   = XW'(q0_next) * DIV_X;
        rem       = x2_reg - qd_reg;
        q_next    = (rem >= DIV_X) ? (q0_reg + QW'(1)) : q0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            x1_reg   <= dividend;
            q0_reg   <= q0_next;
            qd_reg   <= qd_next;
            x2_reg   <= x1_reg;
            q_reg    <= q_next;
        end
    end

    assign quotient = q_reg;

endmodule
`default_nettype wire

>>> hdl/lxz_cube.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lxz_cube
// Four-stage white-scaled cube of a non-negative Q24 term, rounded at
// every product.
// ----------------------------------------------------------------------------
module lxz_cube
    import lxz_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [FY_W-1:0]   term,
    input  wire logic [W_W-1:0]    white,
    output logic      [CUBE_W-1:0] cube
);

    localparam int SQ_W = 2 * FY_W;
    localparam int CU_W = 2 * FY_W + 1;
    localparam int T2_W = FY_W + 1;
    localparam int T3_W = FY_W + 2;
    localparam int WT_W = W_W + T3_W;

    localparam logic [SQ_W-1:0] HALF_SQ = SQ_W'(1) << (FRAC - 1);
    localparam logic [CU_W-1:0] HALF_CU = CU_W'(1) << (FRAC - 1);
    localparam logic [WT_W-1:0] HALF_WT = WT_W'(1) << (FRAC - 1);

    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [FY_W-1:0]   t1_reg;
    logic [SQ_W-1:0]   sq_rnd;
    logic [T2_W-1:0]   t2;
    logic [CU_W-1:0]   cu_reg, cu_next;
    logic [CU_W-1:0]   cu_rnd;
    logic [T3_W-1:0]   t3;
    logic [WT_W-1:0]   wt_reg, wt_next;
    logic [WT_W-1:0]   wt_rnd;
    logic [CUBE_W-1:0] cube_reg, cube_next;

    always_comb
    begin
        sq_next   = SQ_W'(term) * SQ_W'(term);
        sq_rnd    = sq_reg + HALF_SQ;
        t2        = sq_rnd[FRAC +: T2_W];
        cu_next   = CU_W'(t2) * CU_W'(t1_reg);
        cu_rnd    = cu_reg + HALF_CU;
        t3        = cu_rnd[FRAC +: T3_W];
        wt_next   = WT_W'(white) * WT_W'(t3);
        wt_rnd    = wt_reg + HALF_WT;
        cube_next = wt_rnd[FRAC +: CUBE_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= sq_next;
            t1_reg   <= term;
            cu_reg   <= cu_next;
            wt_reg   <= wt_next;
            cube_reg <= cube_next;
        end
    end

    assign cube = cube_reg;

endmodule
`default_nettype wire

>>> hdl/lxz_expand.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lxz_expand
// Inverse companding of one Q24 term with white scaling: cube above the
// knee, linear segment below, both computed in parallel and selected.
// ----------------------------------------------------------------------------
module lxz_expand
    import lxz_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [TERM_W-1:0] term,
    input  wire logic        [W_W-1:0]    white,
    output logic signed      [OUT_W-1:0]  result
);

    localparam int PROD_W = ABS_D_W + W_W;

    logic signed [TERM_W-1:0]    d;
    logic        [ABS_D_W-1:0]   dabs_reg, dabs_next;
    lin_flags_t                  flags_reg, flags_next;
    lin_flags_t                  flags_d;
    logic        [PROD_W-1:0]    prod_reg, prod_next;
    logic        [LIN_SUM_W-1:0] scaled;
    logic        [LIN_X_W-1:0]   v_reg, v_next;
    logic        [LIN_Q_W-1:0]   q_lin;
    logic signed [OUT_W-1:0]     lin_val;
    logic        [CUBE_W-1:0]    cube_raw;
    logic        [CUBE_W-1:0]    cube_d;
    logic signed [OUT_W-1:0]     result_reg, result_next;

    always_comb
    begin
        d              = term - LIN_OFFSET;
        dabs_next      = d[TERM_W-1] ? ABS_D_W'(-d) : ABS_D_W'(d);
        flags_next.lin = (term < KNEE_Q);
        flags_next.neg = d[TERM_W-1];
        prod_next      = PROD_W'(dabs_reg) * PROD_W'(white);
        scaled         = LIN_SUM_W'(prod_reg) * LIN_SUM_W'(LIN_SCALE) + LIN_HALF;
        v_next         = scaled[FRAC +: LIN_X_W];
        lin_val        = signed'(OUT_W'(q_lin));
        if (flags_d.lin)
        begin
            result_next = flags_d.neg ? -lin_val : lin_val;
        end
        else
        begin
            result_next = sat_cube(cube_d);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dabs_reg   <= dabs_next;
            flags_reg  <= flags_next;
            prod_reg   <= prod_next;
            v_reg      <= v_next;
            result_reg <= result_next;
        end
    end

    lxz_const_div #(
        .XW      (LIN_X_W),
        .QW      (LIN_Q_W),
        .DIVISOR (LIN_DIV)
    ) u_lin_div (
        .clk      (clk),
        .en       (en),
        .dividend (v_reg),
        .quotient (q_lin)
    );

    lxz_cube u_cube (
        .clk   (clk),
        .en    (en),
        .term  (term[FY_W-1:0]),
        .white (white),
        .cube  (cube_raw)
    );

    lxz_delay #(
        .WIDTH (CUBE_W),
        .DEPTH (CUBE_DLY)
    ) u_cube_dly (
        .clk  (clk),
        .en   (en),
        .din  (cube_raw),
        .dout (cube_d)
    );

    lxz_delay #(
        .WIDTH ($bits(lin_flags_t)),
        .DEPTH (FLAG_DLY)
    ) u_flag_dly (
        .clk  (clk),
        .en   (en),
        .din  (flags_reg),
        .dout (flags_d)
    );

    assign result = result_reg;

endmodule
`default_nettype wire

>>> hdl/lab_to_xyz_pixel_convert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lab_to_xyz_pixel_convert
// CIELAB to CIE XYZ pixel converter with a programmable reference white.
// ----------------------------------------------------------------------------
// One pixel per clock while output pixels are taken. All stages advance
// together and stall as one when the output register holds a pixel that is
// not taken; the depth is set by the three stage constant dividers for fy,
// a/500, b/200 and the linear segment, and by the three chained cube
// multipliers. White point registers must be written through the cfg port
// by the user while no pixel is in flight (not enforced); index 3 is ignored.
// ----------------------------------------------------------------------------
module lab_to_xyz_pixel_convert
    import lxz_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // lightness[14:0], green_red[30:15], blue_yellow[46:31], zero pad [47]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic                   s_axis_tlast,
    // x_tristim[17:0], y_tristim[35:18], z_tristim[53:36], zero pad [55:54]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic                        m_axis_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [W_W-1:0]         cfg_data
);

    logic                ce;
    logic [PIPE_LAT-1:0] vld_reg, vld_next;

    logic [W_W-1:0] white_x_reg, white_x_next;
    logic [W_W-1:0] white_y_reg, white_y_next;
    logic [W_W-1:0] white_z_reg, white_z_next;

    logic        [L_W-1:0]   l_in;
    logic        [LOW_W-1:0] l_low;
    logic signed [AB_W-1:0]  a_in;
    logic signed [AB_W-1:0]  b_in;
    logic        [AB_W-1:0]  a_mag;
    logic        [AB_W-1:0]  b_mag;
    logic        [L_W:0]     l_ofs;
    logic        [29:0]      yl_sum;
    logic        [26:0]      yl_prod;

    logic [FYL_X_W-1:0] fyl_x_reg, fyl_x_next;
    logic [FYH_X_W-1:0] fyh_x_reg, fyh_x_next;
    logic [YL_X_W-1:0]  yl_x_reg, yl_x_next;
    logic [A_X_W-1:0]   a_x_reg, a_x_next;
    logic [B_X_W-1:0]   b_x_reg, b_x_next;
    prep_side_t         side_reg, side_next;
    prep_side_t         side_d;

    logic [FYL_Q_W-1:0] q_fyl;
    logic [FYH_Q_W-1:0] q_fyh;
    logic [YL_Q_W-1:0]  q_yl;
    logic [A_Q_W-1:0]   q_a;
    logic [B_Q_W-1:0]   q_b;

    logic        [FY_W-1:0]   fy_reg, fy_next;
    logic signed [TERM_W-1:0] fy_s;
    logic signed [TERM_W-1:0] qa_s;
    logic signed [TERM_W-1:0] qb_s;
    logic signed [TERM_W-1:0] tx_reg, tx_next;
    logic signed [TERM_W-1:0] tz_reg, tz_next;
    y_side_t                  yside_reg, yside_next;
    y_side_t                  yside_d;
    logic                     last_reg;
    logic                     last_d;

    logic        [CUBE_W-1:0] y_cube;
    logic        [CUBE_W-1:0] y_cube_d;
    logic signed [OUT_W-1:0]  y_out_reg, y_out_next;
    logic signed [OUT_W-1:0]  x_out;
    logic signed [OUT_W-1:0]  z_out;

    // Global stall: the whole pipe moves when the output slot frees up
    assign ce            = !vld_reg[PIPE_LAT-1] || m_axis_tready;
    assign s_axis_tready = ce;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        vld_next = ce ? {vld_reg[PIPE_LAT-2:0], s_axis_tvalid} : vld_reg;
    end

    always_comb
    begin
        white_x_next = white_x_reg;
        white_y_next = white_y_reg;
        white_z_next = white_z_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_WHITE_X: white_x_next = cfg_data;
                REG_WHITE_Y: white_y_next = cfg_data;
                REG_WHITE_Z: white_z_next = cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            white_x_reg <= WHITE_X_RST;
            white_y_reg <= WHITE_Y_RST;
            white_z_reg <= WHITE_Z_RST;
        end
        else
        begin
            vld_reg     <= vld_next;
            white_x_reg <= white_x_next;
            white_y_reg <= white_y_next;
            white_z_reg <= white_z_next;
        end
    end

    // Stage 1: dividends for the fy, low Y, a/500 and b/200 constant divisions
    always_comb
    begin
        l_in  = s_axis_tdata[L_W-1:0];
        l_low = l_in[LOW_W-1:0];
        a_in  = signed'(s_axis_tdata[L_W +: AB_W]);
        b_in  = signed'(s_axis_tdata[L_W+AB_W +: AB_W]);
        a_mag = a_in[AB_W-1] ? AB_W'(-a_in) : AB_W'(a_in);
        b_mag = b_in[AB_W-1] ? AB_W'(-b_in) : AB_W'(b_in);
        l_ofs = (L_W+1)'(l_in) + (L_W+1)'(L_BIAS);

        fyl_x_next = FYL_X_W'(l_low) * FYL_X_W'(FYL_MULT) + FYL_X_W'(FYL_HALF);
        fyh_x_next = {l_ofs, 14'd0} + FYH_X_W'(FYH_HALF);
        yl_prod    = 27'(l_low) * 27'(white_y_reg);
        yl_sum     = {1'b0, yl_prod, 2'b00} + 30'(yl_prod) + 30'(YL_HALF);
        yl_x_next  = yl_sum[YL_SH +: YL_X_W];
        a_x_next   = {a_mag, 14'd0} + A_X_W'(A_HALF);
        b_x_next   = {b_mag, 13'd0} + B_X_W'(B_HALF);

        side_next.low   = (l_in[L_W-1:LOW_W] == '0);
        side_next.a_neg = a_in[AB_W-1];
        side_next.b_neg = b_in[AB_W-1];
        side_next.last  = s_axis_tlast;
        side_next.bias  = BIAS_W'(l_low) * BIAS_W'(FYL_WHOLE) + FY_OFFSET;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fyl_x_reg <= fyl_x_next;
            fyh_x_reg <= fyh_x_next;
            yl_x_reg  <= yl_x_next;
            a_x_reg   <= a_x_next;
            b_x_reg   <= b_x_next;
            side_reg  <= side_next;
        end
    end

    lxz_const_div #(.XW(FYL_X_W), .QW(FYL_Q_W), .DIVISOR(FYL_DIV)) u_fyl_div (
        .clk (clk), .en (ce), .dividend (fyl_x_reg), .quotient (q_fyl)
    );

    lxz_const_div #(.XW(FYH_X_W), .QW(FYH_Q_W), .DIVISOR(FYH_DIV)) u_fyh_div (
        .clk (clk), .en (ce), .dividend (fyh_x_reg), .quotient (q_fyh)
    );

    lxz_const_div #(.XW(YL_X_W), .QW(YL_Q_W), .DIVISOR(YL_DIV)) u_yl_div (
        .clk (clk), .en (ce), .dividend (yl_x_reg), .quotient (q_yl)
    );

    lxz_const_div #(.XW(A_X_W), .QW(A_Q_W), .DIVISOR(A_DIV)) u_a_div (
        .clk (clk), .en (ce), .dividend (a_x_reg), .quotient (q_a)
    );

    lxz_const_div #(.XW(B_X_W), .QW(B_Q_W), .DIVISOR(B_DIV)) u_b_div (
        .clk (clk), .en (ce), .dividend (b_x_reg), .quotient (q_b)
    );

    lxz_delay #(.WIDTH($bits(prep_side_t)), .DEPTH(DIV_LAT)) u_side_dly (
        .clk (clk), .en (ce), .din (side_reg), .dout (side_d)
    );

    // Form fy, tx and tz
    always_comb
    begin
        if (side_d.low)
        begin
            fy_next = FY_W'(q_fyl) + FY_W'(side_d.bias);
        end
        else
        begin
            fy_next = q_fyh;
        end
        fy_s            = signed'(TERM_W'(fy_next));
        qa_s            = signed'(TERM_W'(q_a));
        qb_s            = signed'(TERM_W'(q_b));
        tx_next         = side_d.a_neg ? (fy_s - qa_s) : (fy_s + qa_s);
        tz_next         = side_d.b_neg ? (fy_s + qb_s) : (fy_s - qb_s);
        yside_next.low  = side_d.low;
        yside_next.ylow = q_yl;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fy_reg    <= fy_next;
            tx_reg    <= tx_next;
            tz_reg    <= tz_next;
            yside_reg <= yside_next;
            last_reg  <= side_d.last;
        end
    end

    lxz_expand u_x_expand (
        .clk (clk), .en (ce), .term (tx_reg), .white (white_x_reg), .result (x_out)
    );

    lxz_expand u_z_expand (
        .clk (clk), .en (ce), .term (tz_reg), .white (white_z_reg), .result (z_out)
    );

    lxz_cube u_y_cube (
        .clk (clk), .en (ce), .term (fy_reg), .white (white_y_reg), .cube (y_cube)
    );

    lxz_delay #(.WIDTH(CUBE_W), .DEPTH(Y_CUBE_DLY)) u_y_cube_dly (
        .clk (clk), .en (ce), .din (y_cube), .dout (y_cube_d)
    );

    lxz_delay #(.WIDTH($bits(y_side_t)), .DEPTH(Y_SIDE_DLY)) u_y_side_dly (
        .clk (clk), .en (ce), .din (yside_reg), .dout (yside_d)
    );

    lxz_delay #(.WIDTH(1), .DEPTH(EXP_LAT)) u_last_dly (
        .clk (clk), .en (ce), .din (last_reg), .dout (last_d)
    );

    always_comb
    begin
        if (yside_d.low)
        begin
            y_out_next = signed'(OUT_W'(yside_d.ylow));
        end
        else
        begin
            y_out_next = sat_cube(y_cube_d);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            y_out_reg <= y_out_next;
        end
    end

    assign m_axis_tvalid = vld_reg[PIPE_LAT-1];
    assign m_axis_tdata  = {2'b00, z_out, y_out_reg, x_out};
    assign m_axis_tlast  = last_d;

endmodule
`default_nettype wire

>>> bench/lab_to_xyz_pixel_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lab_to_xyz_pixel_convert_tb
// Self-checking bench for the CIELAB to XYZ pixel converter. Pixels stream in
// through the slave port and results are checked against a fixed-point
// model of the conversion kept inside the bench. Directed corners come
// first: segment edges, the knee, negative terms, lightness above 100 and
// saturation. Long random runs follow under several reference whites. Both
// stream sides idle at random, except for one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module lab_to_xyz_pixel_convert_tb;
    import lxz_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int     IDLE_PCT       = 11;
    localparam int     PHASE_PIXELS   = 300;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     FLUSH_CYCLES   = 40;
    localparam int     REPORT_MAX     = 10;
    localparam int     L_LOW_LIMIT    = 2048;

    localparam longint Q24_HALF     = 64'sd1 <<< 23;
    localparam longint FY_BIAS_Q24  = ((64'sd16 <<< 24) + 58) / 116;
    localparam longint KNEE_Q24     = ((64'sd2069 <<< 24) + 5000) / 10000;
    localparam longint LIN_BIAS_Q24 = ((64'sd13793 <<< 24) + 50000) / 100000;
    localparam longint LIN_DEN      = 64'sd7787 <<< 24;
    localparam longint OUT_HI       = 131071;
    localparam longint OUT_LO       = -131072;

    typedef struct packed {
        logic signed [OUT_W-1:0] x_val;
        logic signed [OUT_W-1:0] y_val;
        logic signed [OUT_W-1:0] z_val;
        logic                    last;
    } xyz_pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic                   s_axis_tlast = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [W_W-1:0]         cfg_data = '0;

    logic [W_W-1:0] white_x_now = WHITE_X_RST;
    logic [W_W-1:0] white_y_now = WHITE_Y_RST;
    logic [W_W-1:0] white_z_now = WHITE_Z_RST;

    xyz_pixel_t xyz_expect[$];
    int         fail_count = 0;
    int         idle_cycles = 0;
    bit         stall_en = 1'b1;

    lab_to_xyz_pixel_convert u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Conversion model
    // ------------------------------------------------------------------
    // nearest, ties away from zero; den > 0
    function automatic longint div_nearest(input longint num, input longint den);
        if (num < 0)
        begin
            return -((-num + den / 2) / den);
        end
        return (num + den / 2) / den;
    endfunction

    function automatic longint white_cube(input longint t, input longint w);
        longint t2;
        longint t3;
        t2 = (t * t + Q24_HALF) >>> 24;
        t3 = (t2 * t + Q24_HALF) >>> 24;
        return (w * t3 + Q24_HALF) >>> 24;
    endfunction

    function automatic longint companded(input longint t, input longint w);
        if (t < KNEE_Q24)
        begin
            return div_nearest((t - LIN_BIAS_Q24) * w * 1000, LIN_DEN);
        end
        return white_cube(t, w);
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
        if (v > OUT_HI)
        begin
            return OUT_W'(OUT_HI);
        end
        if (v < OUT_LO)
        begin
            return OUT_W'(OUT_LO);
        end
        return OUT_W'(v);
    endfunction

    function automatic xyz_pixel_t lab_to_xyz(input logic [IN_TDATA_W-1:0] data,
                                              input logic last);
        longint     l;
        longint     a;
        longint     b;
        longint     fy;
        longint     y;
        longint     tx;
        longint     tz;
        xyz_pixel_t px;
        l = longint'(data[L_W-1:0]);
        a = longint'(signed'(data[L_W +: AB_W]));
        b = longint'(signed'(data[L_W+AB_W +: AB_W]));
        if (l < L_LOW_LIMIT)
        begin
            fy = div_nearest(l * 7787 * 65536, 903300) + FY_BIAS_Q24;
            y  = div_nearest(l * longint'(white_y_now) * 10, 256 * 9033);
        end
        else
        begin
            fy = div_nearest((l + 4096) * 65536, 116);
            y  = white_cube(fy, longint'(white_y_now));
        end
        tx = fy + div_nearest(a * 65536, 500);
        tz = fy - div_nearest(b * 65536, 200);
        px.x_val = clamp_out(companded(tx, longint'(white_x_now)));
        px.y_val = clamp_out(y);
        px.z_val = clamp_out(companded(tz, longint'(white_z_now)));
        px.last  = last;
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Transaction monitor, scoreboard and watchdog
    // ------------------------------------------------------------------
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
        begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    always @(posedge clk)
    begin
        xyz_pixel_t got;
        xyz_pixel_t want;
        bit         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                got.x_val = m_axis_tdata[OUT_W-1:0];
                got.y_val = m_axis_tdata[OUT_W +: OUT_W];
                got.z_val = m_axis_tdata[2*OUT_W +: OUT_W];
                got.last  = m_axis_tlast;
                if (xyz_expect.size() == 0)
                begin
                    note_failure($sformatf("unexpected pixel x=%0d y=%0d z=%0d last=%0b",
                                           got.x_val, got.y_val, got.z_val, got.last));
                end
                else
                begin
                    want = xyz_expect.pop_front();
                    if (got !== want)
                    begin
                        note_failure($sformatf(
                            "exp x=%0d y=%0d z=%0d last=%0b  got x=%0d y=%0d z=%0d last=%0b",
                            want.x_val, want.y_val, want.z_val, want.last,
                            got.x_val, got.y_val, got.z_val, got.last));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                xyz_expect.push_back(lab_to_xyz(s_axis_tdata, s_axis_tlast));
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    REG_WHITE_X: white_x_now <= cfg_data;
                    REG_WHITE_Y: white_y_now <= cfg_data;
                    REG_WHITE_Z: white_z_now <= cfg_data;
                    default: ;
                endcase
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= !stall_en || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [L_W-1:0] l, input logic [AB_W-1:0] a,
                              input logic [AB_W-1:0] b, input logic last);
        while (stall_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, b, a, l};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_pipeline_empty();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (xyz_expect.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // writes to the spare index must not disturb the whites
    task automatic set_white(input logic [W_W-1:0] wx, input logic [W_W-1:0] wy,
                             input logic [W_W-1:0] wz);
        wait_pipeline_empty();
        write_reg(REG_WHITE_X, wx);
        write_reg(REG_WHITE_Y, wy);
        write_reg(REG_WHITE_Z, wz);
        write_reg(REG_UNUSED, W_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [L_W-1:0] pick_lightness();
        case ($urandom_range(0, 9))
            0, 1:    return L_W'($urandom_range(0, L_LOW_LIMIT - 1));
            2:       return L_W'($urandom_range(1980, 2120));
            3, 4:    return L_W'($urandom);
            default: return L_W'($urandom_range(0, 25600));
        endcase
    endfunction

    function automatic logic [AB_W-1:0] pick_chroma();
        if ($urandom_range(0, 1) == 0)
        begin
            return AB_W'($urandom);
        end
        return AB_W'(int'($urandom_range(0, 12000)) - 6000);
    endfunction

    task automatic send_corners();
        send_pixel(15'd32767, 16'sd32767, -16'sd32768, 1'b1);
        send_pixel(15'd25600, 16'd0, 16'd0, 1'b0);
        send_pixel(15'd0, -16'sd32768, 16'sd32767, 1'b0);
        send_pixel(15'd2047, 16'sd100, -16'sd100, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_default_white();
        send_pixel(15'd0, 16'd0, 16'd0, 1'b0);
        send_pixel(15'd2047, 16'd0, 16'd0, 1'b0);
        send_pixel(15'd2048, 16'd0, 16'd0, 1'b1);
        send_pixel(15'd2048, 16'sd1, 16'd0, 1'b0);
        send_pixel(15'd2048, -16'sd1, 16'sd1, 1'b0);
        send_pixel(15'd25600, 16'd0, 16'd0, 1'b0);
        send_pixel(15'd32767, 16'd0, 16'd0, 1'b1);
        send_pixel(15'd12800, 16'sd32767, -16'sd32768, 1'b0);
        send_pixel(15'd12800, -16'sd32768, 16'sd32767, 1'b0);
        send_pixel(15'd0, -16'sd32768, 16'sd32767, 1'b1);
        send_pixel(15'd25600, 16'sd32767, -16'sd32768, 1'b0);
        send_pixel(15'd16384, 16'sd21845, -16'sd21846, 1'b1);
    endtask

    task automatic test_white_extremes();
        set_white(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_corners();
        set_white(16'h0000, 16'h0000, 16'h0000);
        send_corners();
        set_white(16'h0001, 16'hFFFF, 16'h0000);
        send_corners();
    endtask

    task automatic test_random_pixels();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0, 4:    set_white(WHITE_X_RST, WHITE_Y_RST, WHITE_Z_RST);
                2:       set_white(W_W'($urandom_range(22000, 26000)),
                                   W_W'($urandom_range(23000, 28000)),
                                   W_W'($urandom_range(25000, 30000)));
                default: set_white(W_W'($urandom), W_W'($urandom), W_W'($urandom));
            endcase
            stall_en = (phase != 2);
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                send_pixel(pick_lightness(), pick_chroma(), pick_chroma(),
                           $urandom_range(0, 7) == 0);
            end
        end
        stall_en = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_white();
        test_white_extremes();
        test_random_pixels();
        wait_pipeline_empty();
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (fail_count == 0 && xyz_expect.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
